>>> sv/jpn_pkg.sv
// Shared types, character codes and lookup functions of the jailed path normalizer.
`timescale 1ns / 1ps

package jpn_pkg;

  localparam int unsigned ROOT_BYTES = 6;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_COLON  = 8'h3A;

  // Prefix recognizer phases.
  localparam logic [2:0] PH_START = 3'd0;
  localparam logic [2:0] PH_FIRST = 3'd1;
  localparam logic [2:0] PH_MATCH = 3'd2;
  localparam logic [2:0] PH_TAIL  = 3'd6;
  localparam logic [2:0] PH_PASS  = 3'd7;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_DENIED  = 2'd1,
    ST_INVALID = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_CHAR,
    OP_END
  } op_e;

  // Work one pushed item leaves for the core: the held first character,
  // a count of held jail characters, then the final operation.
  typedef struct packed {
    logic       lead;
    logic [2:0] jn;
    op_e        fin;
  } plan_t;

  typedef struct packed {
    logic push;
    logic refill;
  } stk_ctl_t;

  function automatic logic is_sep(input logic [7:0] c);
    return (c == CH_SLASH) || (c == CH_BSLASH);
  endfunction

  function automatic logic [7:0] jail_char(input logic [1:0] k);
    logic [7:0] r;
    unique case (k)
      2'd0: r = 8'h2F;
      2'd1: r = 8'h73;
      2'd2: r = 8'h72;
      2'd3: r = 8'h76;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] root_char(input logic [2:0] i);
    logic [7:0] r;
    case (i)
      3'd0: r = 8'h30;
      3'd1: r = 8'h3A;
      3'd2: r = 8'h2F;
      3'd3: r = 8'h73;
      3'd4: r = 8'h72;
      3'd5: r = 8'h76;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

>>> sv/jpn_prefix.sv
// Drive prefix and jail prefix recognizer that plans the core work of one push.
`timescale 1ns / 1ps

module jpn_prefix (
  input  logic [2:0]    phase_i,
  input  logic [7:0]    first_i,
  input  logic [7:0]    char_i,
  output jpn_pkg::plan_t plan_o,
  output logic [2:0]    phase_o,
  output logic          load_first_o
);
  import jpn_pkg::*;

  always_comb begin
    logic [2:0] k;
    k = phase_i - PH_MATCH;
    plan_o = '{lead: 1'b0, jn: 3'd0, fin: OP_NONE};
    phase_o = phase_i;
    load_first_o = 1'b0;
    if (char_i != CH_NUL) begin
      priority if (phase_i == PH_START) begin
        load_first_o = 1'b1;
        phase_o = PH_FIRST;
      end else if (phase_i == PH_FIRST) begin
        priority if (char_i == CH_COLON) begin
          phase_o = PH_MATCH;
        end else if (first_i == CH_SLASH && char_i == jail_char(2'd1)) begin
          phase_o = PH_MATCH + 3'd2;
        end else if (first_i == CH_SLASH) begin
          phase_o = PH_PASS;
          plan_o.jn = 3'd1;
          plan_o.fin = OP_CHAR;
        end else begin
          phase_o = PH_PASS;
          plan_o.lead = 1'b1;
          plan_o.fin = OP_CHAR;
        end
      end else if (phase_i < PH_TAIL) begin
        if (char_i == jail_char(k[1:0])) begin
          phase_o = phase_i + 3'd1;
        end else begin
          phase_o = PH_PASS;
          plan_o.jn = {1'b0, k[1:0]};
          plan_o.fin = OP_CHAR;
        end
      end else if (phase_i == PH_TAIL) begin
        phase_o = PH_PASS;
        plan_o.jn = is_sep(char_i) ? 3'd0 : 3'd4;
        plan_o.fin = OP_CHAR;
      end else begin
        plan_o.fin = OP_CHAR;
      end
    end else begin
      phase_o = PH_PASS;
      plan_o.fin = OP_END;
      priority if (phase_i == PH_FIRST) begin
        if (first_i == CH_SLASH) begin
          plan_o.jn = 3'd1;
        end else begin
          plan_o.lead = 1'b1;
        end
      end else if (phase_i >= PH_MATCH && phase_i < PH_TAIL) begin
        plan_o.jn = {1'b0, k[1:0]};
      end else begin
        plan_o.jn = 3'd0;
      end
    end
  end

endmodule

>>> sv/jpn_path_mem.sv
// Output path byte memory with one write port and one registered read port.
`timescale 1ns / 1ps

module jpn_path_mem #(
  parameter int unsigned PATH_MAX = 128,
  localparam int unsigned AW = $clog2(PATH_MAX)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [7:0]    rdata_o
);
  logic [7:0] mem [PATH_MAX];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/jpn_seg_stack.sv
// Segment start stack in memory with a top-of-stack register refilled after a pop.
`timescale 1ns / 1ps

module jpn_seg_stack #(
  parameter int unsigned STACK_DEPTH = 32,
  localparam int unsigned SA = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  jpn_pkg::stk_ctl_t ctl_i,
  input  logic [SA-1:0]     wr_addr_i,
  input  logic [7:0]        wr_data_i,
  input  logic [SA-1:0]     rd_addr_i,
  output logic [7:0]        top_o
);
  import jpn_pkg::*;

  logic [7:0] mem [STACK_DEPTH];
  logic [7:0] rd_q;
  logic [7:0] top_q;
  logic       pend_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.push) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (ctl_i.refill) begin
      rd_q <= mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
      top_q  <= 8'd0;
    end else begin
      pend_q <= ctl_i.refill;
      if (ctl_i.push) begin
        top_q <= wr_data_i;
      end else if (pend_q) begin
        top_q <= rd_q;
      end
    end
  end

  // The refilled entry is used straight from the read register in its first cycle.
  assign top_o = pend_q ? rd_q : top_q;

endmodule

>>> sv/jailed_path_normalizer.sv
// Top level of the jailed path normalizer: handshakes, core segment logic and result register.
//
// Usage. Input transactions carry action_i, char_code_i and read_index_i on
// in_valid_i / in_stall_o. A push (action 0) feeds one path character; a zero
// character ends the path and yields one result transaction with status and
// length. A read (action 1) yields one result with the byte at read_index_i.
// Results leave on out_valid_o / out_stall_i from a single output register.
// The configuration channel (cfg_valid_i, cfg_ready_o, cfg_data_i) writes buffer_size;
// it is always ready. The user must write it only while the block is idle; the block
// does not enforce this. Throughput: one item per cycle while no prefix replay is busy.
// A push that breaks off a held-back drive or "/srv" prefix replays up to four held
// characters through the one path memory write port and takes no new item meanwhile;
// a terminator after a held prefix likewise. Results appear in the cycle after the
// cycle that finishes the item. Pushes that give no result are accepted while a result
// is stalled at the output; reads and terminators wait until the output register frees.
// Reset returns the root "0:/srv", buffer_size 128 and an empty stack; there is no
// clearing pass, because no memory entry is read before it is written.
`timescale 1ns / 1ps

module jailed_path_normalizer #(
  parameter int unsigned PATH_MAX    = 128,
  parameter int unsigned STACK_DEPTH = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       action_i,
  input  logic [7:0] char_code_i,
  input  logic [6:0] read_index_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] status_o,
  output logic [7:0] path_length_o,
  output logic [7:0] out_byte_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [7:0] cfg_data_i
);
  import jpn_pkg::*;

  localparam int unsigned AW = $clog2(PATH_MAX);
  localparam int unsigned DW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned SA = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned IW = (AW > 7) ? AW : 7;

  // Core path state.
  logic [7:0]    len_q, len_d;
  logic [7:0]    seg_q, seg_d;
  logic          dot_q, dot_d;
  logic [DW-1:0] depth_q, depth_d;
  status_e       err_q, err_d;
  logic [7:0]    buf_q;

  // Prefix state and item bookkeeping.
  logic [2:0] phase_q;
  logic       done_q;
  logic [7:0] first_q;
  logic       busy_q;
  plan_t      rp_q;
  logic [2:0] rp_jidx_q;
  logic [7:0] rp_c_q;

  // Output register.
  logic       out_valid_q;
  status_e    out_status_q;
  logic [7:0] out_len_q;
  logic       out_mem_q;
  logic [7:0] out_const_q;

  plan_t      acc_plan;
  logic [2:0] acc_phase, cur_phase;
  logic       acc_load;
  logic       acc_head_end;

  plan_t      act_plan, rem_plan;
  logic [2:0] act_jidx, rem_jidx;
  logic [7:0] act_c;
  op_e        head_op;
  logic [7:0] head_c;
  logic       head_end, rem_busy;

  logic out_free, accept, acc_push, acc_read, exec, fresh, result;

  logic          pw_en;
  logic [AW-1:0] pw_addr;
  logic [7:0]    pw_data;
  stk_ctl_t      stk_ctl;
  logic [SA-1:0] stk_waddr, stk_raddr;
  logic [7:0]    stk_wdata, stk_top;
  logic [7:0]    mem_rdata;

  status_e    res_status;
  logic [7:0] res_len;
  logic       rd_hit, rd_root;
  logic [IW-1:0] idx_ext;

  // A new path starts from the root when a push follows a finished path.
  assign cur_phase = done_q ? PH_START : phase_q;

  jpn_prefix u_prefix (
    .phase_i      (cur_phase),
    .first_i      (first_q),
    .char_i       (char_code_i),
    .plan_o       (acc_plan),
    .phase_o      (acc_phase),
    .load_first_o (acc_load)
  );

  assign acc_head_end = !acc_plan.lead && (acc_plan.jn == 3'd0) && (acc_plan.fin == OP_END);
  assign out_free     = !out_valid_q || !out_stall_i;

  // Items that produce a result need the output register to be free.
  assign in_stall_o = busy_q || (!out_free && (action_i || acc_head_end));
  assign accept     = in_valid_i && !in_stall_o;
  assign acc_push   = accept && !action_i;
  assign acc_read   = accept && action_i;

  // Pick the next core operation from the pending plan.
  always_comb begin
    act_plan = busy_q ? rp_q : acc_plan;
    act_jidx = busy_q ? rp_jidx_q : 3'd0;
    act_c    = busy_q ? rp_c_q : char_code_i;
    rem_plan = act_plan;
    rem_jidx = act_jidx;
    head_op  = OP_NONE;
    head_c   = act_c;
    priority if (act_plan.lead) begin
      head_op = OP_CHAR;
      head_c = first_q;
      rem_plan.lead = 1'b0;
    end else if (act_jidx < act_plan.jn) begin
      head_op = OP_CHAR;
      head_c = jail_char(act_jidx[1:0]);
      rem_jidx = act_jidx + 3'd1;
    end else if (act_plan.fin != OP_NONE) begin
      head_op = act_plan.fin;
      rem_plan.fin = OP_NONE;
    end else begin
      head_op = OP_NONE;
    end
    rem_busy = rem_plan.lead || (rem_jidx < rem_plan.jn) || (rem_plan.fin != OP_NONE);
  end

  assign head_end = (head_op == OP_END);
  assign exec     = busy_q ? (!head_end || out_free) : acc_push;
  assign fresh    = acc_push && done_q;
  assign result   = (exec && head_end) || acc_read;

  // Core operation: append a character or close the current segment.
  always_comb begin
    logic [7:0]    cur_len, cur_seg;
    logic          cur_dot;
    logic [DW-1:0] cur_depth;
    status_e       cur_err;
    op_e           op;
    logic          do_chr, do_end;
    logic [9:0]    pos;
    logic [7:0]    eff;
    cur_len   = fresh ? 8'(ROOT_BYTES) : len_q;
    cur_seg   = fresh ? 8'd0 : seg_q;
    cur_dot   = fresh ? 1'b1 : dot_q;
    cur_depth = fresh ? '0 : depth_q;
    cur_err   = fresh ? ST_OK : err_q;
    op        = exec ? head_op : OP_NONE;
    eff       = (buf_q < 8'(PATH_MAX)) ? buf_q : 8'(PATH_MAX);
    pos       = 10'(cur_len) + 10'd1 + 10'(cur_seg);
    do_chr    = (op == OP_CHAR) && (cur_err == ST_OK) && !is_sep(head_c);
    do_end    = (op == OP_END) || ((op == OP_CHAR) && (cur_err == ST_OK) && is_sep(head_c));

    len_d   = cur_len;
    seg_d   = cur_seg;
    dot_d   = cur_dot;
    depth_d = cur_depth;
    err_d   = cur_err;
    pw_en   = 1'b0;
    pw_addr = pos[AW-1:0];
    pw_data = head_c;
    stk_ctl = '{push: 1'b0, refill: 1'b0};
    stk_waddr = cur_depth[SA-1:0];
    stk_wdata = cur_len + 8'd1;
    stk_raddr = SA'(cur_depth - DW'(1) - DW'(1));

    if (do_chr) begin
      pw_en = (pos < 10'(PATH_MAX));
      if (head_c != CH_DOT) begin
        dot_d = 1'b0;
      end
      if (cur_seg != 8'hFF) begin
        seg_d = cur_seg + 8'd1;
      end
    end

    if (do_end) begin
      seg_d = 8'd0;
      dot_d = 1'b1;
      if (cur_seg != 8'd0 && cur_err == ST_OK) begin
        priority if (cur_dot && cur_seg == 8'd1) begin
          seg_d = 8'd0;
        end else if (cur_dot && cur_seg == 8'd2) begin
          if (cur_depth == '0) begin
            err_d = ST_DENIED;
          end else begin
            depth_d = cur_depth - DW'(1);
            len_d = stk_top - 8'd1;
            stk_ctl.refill = (cur_depth > DW'(1));
          end
        end else if (cur_depth >= DW'(STACK_DEPTH)) begin
          err_d = ST_INVALID;
        end else if (10'(cur_len) + 10'(cur_seg) + 10'd2 > 10'(eff)) begin
          err_d = ST_INVALID;
        end else begin
          pw_en = 1'b1;
          pw_addr = cur_len[AW-1:0];
          pw_data = CH_SLASH;
          stk_ctl.push = 1'b1;
          depth_d = cur_depth + DW'(1);
          len_d = cur_len + 8'd1 + cur_seg;
        end
      end
    end
  end

  jpn_path_mem #(.PATH_MAX(PATH_MAX)) u_path_mem (
    .clk_i   (clk_i),
    .we_i    (pw_en),
    .waddr_i (pw_addr),
    .wdata_i (pw_data),
    .re_i    (acc_read),
    .raddr_i (idx_ext[AW-1:0]),
    .rdata_o (mem_rdata)
  );

  jpn_seg_stack #(.STACK_DEPTH(STACK_DEPTH)) u_seg_stack (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (stk_ctl),
    .wr_addr_i (stk_waddr),
    .wr_data_i (stk_wdata),
    .rd_addr_i (stk_raddr),
    .top_o     (stk_top)
  );

  // Result fields. A small buffer overrides any path error.
  assign idx_ext    = IW'(read_index_i);
  assign res_status = (buf_q <= 8'(ROOT_BYTES + 1)) ? ST_INVALID : err_d;
  assign res_len    = (res_status == ST_OK) ? len_d : 8'd0;
  assign rd_hit     = acc_read && ({1'b0, read_index_i} < res_len);
  assign rd_root    = (read_index_i < 7'(ROOT_BYTES));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= 8'(ROOT_BYTES);
      seg_q       <= 8'd0;
      dot_q       <= 1'b1;
      depth_q     <= '0;
      err_q       <= ST_OK;
      buf_q       <= 8'd128;
      phase_q     <= PH_START;
      done_q      <= 1'b0;
      busy_q      <= 1'b0;
      rp_q        <= '{lead: 1'b0, jn: 3'd0, fin: OP_NONE};
      rp_jidx_q   <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        buf_q <= cfg_data_i;
      end
      if (exec) begin
        len_q     <= len_d;
        seg_q     <= seg_d;
        dot_q     <= dot_d;
        depth_q   <= depth_d;
        err_q     <= err_d;
        busy_q    <= rem_busy;
        rp_q      <= rem_plan;
        rp_jidx_q <= rem_jidx;
      end
      if (acc_push) begin
        phase_q <= acc_phase;
        done_q  <= (char_code_i == CH_NUL);
      end
      if (result) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (exec) begin
      rp_c_q <= act_c;
    end
    if (acc_push && acc_load) begin
      first_q <= char_code_i;
    end
    if (result) begin
      out_status_q <= res_status;
      out_len_q    <= res_len;
      out_mem_q    <= rd_hit && !rd_root;
      out_const_q  <= (rd_hit && rd_root) ? root_char(read_index_i[2:0]) : 8'd0;
    end
  end

  assign cfg_ready_o   = 1'b1;
  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign path_length_o = out_len_q;
  assign out_byte_o    = out_mem_q ? mem_rdata : out_const_q;

  // A failed status never reports a length.
  a_err_no_len : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != 2'd0) |-> (path_length_o == 8'd0))
    else $error("nonzero status with nonzero length");

  // While a plan is replaying, no new transaction may enter.
  a_busy_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> in_stall_o)
    else $error("input accepted during prefix replay");

  // The stack never grows past its depth.
  a_depth : assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= DW'(STACK_DEPTH))
    else $error("segment depth overflow");

  // A result is loaded only when the output could take it.
  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !result)
    else $error("result overwrote a stalled output");

endmodule

>>> bench/testbench.sv
// Self-checking bench for the jailed path normalizer: directed cases, then random paths.
`timescale 1ns / 1ps

module testbench;
  import jpn_pkg::*;

  localparam int unsigned PATH_MAX    = 128;
  localparam int unsigned STACK_DEPTH = 32;
  localparam int unsigned DRAIN_CYCLES = 16;

  // Predictor phases mirror the prefix recognizer of the block.
  localparam logic [2:0] P_START = PH_START;
  localparam logic [2:0] P_FIRST = PH_FIRST;
  localparam logic [2:0] P_MATCH = PH_MATCH;
  localparam logic [2:0] P_PASS  = PH_PASS;

  localparam logic ACT_PUSH = 1'b0;
  localparam logic ACT_READ = 1'b1;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] length;
    logic [7:0] data;
  } path_result_t;

  typedef struct {
    logic       action;
    logic [7:0] ch;
    logic [6:0] idx;
    logic       has_fixed;   // Expected result typed into the table.
    path_result_t fixed;
  } stim_row_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic       action_i = 1'b0;
  logic [7:0] char_code_i = 8'd0;
  logic [6:0] read_index_i = 7'd0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [1:0] status_o;
  logic [7:0] path_length_o;
  logic [7:0] out_byte_o;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [7:0] cfg_data_i = 8'd0;

  always #5 clk_i = ~clk_i;

  jailed_path_normalizer #(.PATH_MAX(PATH_MAX), .STACK_DEPTH(STACK_DEPTH)) dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .action_i, .char_code_i, .read_index_i,
    .out_valid_o, .out_stall_i, .status_o, .path_length_o, .out_byte_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i
  );

  // ---------------------------------------------------------------------------
  // Predictor state: an independent copy of the normalizer.
  // ---------------------------------------------------------------------------
  logic [7:0] m_bufsize;
  logic [7:0] m_store [PATH_MAX];
  logic [7:0] m_starts [STACK_DEPTH];
  int unsigned m_depth, m_len, m_seglen;
  logic [7:0] m_window [5];
  logic [2:0] m_phase;
  logic [1:0] m_err;
  logic       m_dots;
  logic       m_done;

  path_result_t expected_results [$];
  int unsigned  mismatch_count = 0;
  logic         receiver_hold = 1'b0;   // Forces a long output stall.

  function automatic logic sep_char(logic [7:0] c);
    return c == CH_SLASH || c == CH_BSLASH;
  endfunction

  task automatic restart_path();
    m_store[0] = "0"; m_store[1] = ":"; m_store[2] = "/";
    m_store[3] = "s"; m_store[4] = "r"; m_store[5] = "v";
    m_depth = 0; m_len = ROOT_BYTES; m_seglen = 0; m_phase = P_START;
    m_err = ST_OK; m_dots = 1'b1; m_done = 1'b0;
  endtask

  function automatic int unsigned usable_size();
    return (m_bufsize < PATH_MAX) ? m_bufsize : PATH_MAX;
  endfunction

  // Closes the segment being collected: skip, climb, or append.
  task automatic close_segment();
    int unsigned n;
    logic dots;
    n = m_seglen; dots = m_dots;
    m_seglen = 0; m_dots = 1'b1;
    if (n == 0 || m_err != ST_OK) return;
    if (dots && n == 1) return;
    if (dots && n == 2) begin
      if (m_depth == 0) begin
        m_err = ST_DENIED;
        return;
      end
      m_depth--;
      m_len = m_starts[m_depth] - 1;
      return;
    end
    if (m_depth >= STACK_DEPTH || m_len + n + 2 > usable_size()) begin
      m_err = ST_INVALID;
      return;
    end
    m_store[m_len] = CH_SLASH;
    m_starts[m_depth] = 8'(m_len + 1);
    m_depth++;
    m_len = m_len + 1 + n;
  endtask

  task automatic core_feed(logic [7:0] c);
    int unsigned pos;
    if (m_err != ST_OK) return;
    if (sep_char(c)) begin
      close_segment();
      return;
    end
    pos = m_len + 1 + m_seglen;
    if (pos < PATH_MAX) m_store[pos] = c;
    if (c != CH_DOT) m_dots = 1'b0;
    if (m_seglen < 255) m_seglen++;
  endtask

  task automatic replay_window(int unsigned k);
    for (int unsigned i = 0; i < k && i < 5; i++) core_feed(m_window[i]);
  endtask

  // Matching of the "/srv" jail prefix, held back until it is decided.
  task automatic jail_match(logic [7:0] c);
    int unsigned k;
    k = m_phase - P_MATCH;
    if (k < 4) begin
      if (c == jail_char(2'(k))) begin
        m_window[k] = c;
        m_phase++;
        return;
      end
      replay_window(k);
    end else if (!sep_char(c)) begin
      replay_window(4);
    end
    m_phase = P_PASS;
    core_feed(c);
  endtask

  task automatic path_char(logic [7:0] c);
    logic [7:0] first;
    if (m_phase == P_START) begin
      m_window[0] = c;
      m_phase = P_FIRST;
    end else if (m_phase == P_FIRST) begin
      first = m_window[0];
      m_phase = P_MATCH;
      // A colon in second place drops the drive prefix.
      if (c != CH_COLON) begin
        jail_match(first);
        if (m_phase == P_PASS) core_feed(c);
        else jail_match(c);
      end
    end else if (m_phase < P_PASS) begin
      jail_match(c);
    end else begin
      core_feed(c);
    end
  endtask

  task automatic path_end();
    if (m_phase == P_FIRST) begin
      m_phase = P_MATCH;
      jail_match(m_window[0]);
    end
    if (m_phase != P_START && m_phase < P_PASS) begin
      if (m_phase - P_MATCH < 4) replay_window(m_phase - P_MATCH);
      m_phase = P_PASS;
    end
    close_segment();
    m_done = 1'b1;
  endtask

  // Applies one accepted input transaction; yields is set when it gives a result.
  task automatic normalize_item(input logic act, input logic [7:0] c, input logic [6:0] idx,
                                output path_result_t r, output logic yields);
    r = '0;
    yields = 1'b0;
    if (act == ACT_PUSH) begin
      if (m_done) restart_path();
      if (c != CH_NUL) begin
        path_char(c);
        return;
      end
      path_end();
    end
    r.status = (m_bufsize <= ROOT_BYTES + 1) ? ST_INVALID : m_err;
    r.length = (r.status == ST_OK) ? 8'(m_len) : 8'd0;
    if (act == ACT_READ && idx < r.length) r.data = m_store[idx];
    yields = 1'b1;
  endtask

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Sender side.
  // ---------------------------------------------------------------------------
  stim_row_t directed [$];

  // Valid stays high between back-to-back items and drops only for a gap.
  task automatic send_item(logic act, logic [7:0] c, logic [6:0] idx, int unsigned gap);
    path_result_t r;
    logic yields;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    action_i     <= act;
    char_code_i  <= c;
    read_index_i <= idx;
    do @(posedge clk_i); while (in_stall_o);
    normalize_item(act, c, idx, r, yields);
    if (yields) expected_results.push_back(r);
  endtask

  task automatic send_gapped(logic act, logic [7:0] c, logic [6:0] idx);
    send_item(act, c, idx, ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11));
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_gapped(ACT_PUSH, s[i], 7'd0);
  endtask

  // Waits for all results, then lets the block settle before a register write.
  task automatic drain();
    int unsigned guard;
    guard = 0;
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0 && guard < 100000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_bufsize(logic [7:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    m_bufsize = v;
  endtask

  function automatic logic [7:0] random_path_char();
    case ($urandom_range(0, 9))
      0, 1: return CH_SLASH;
      2: return CH_BSLASH;
      3, 4: return CH_DOT;
      5: return CH_COLON;
      6: return 8'($urandom_range(1, 255));
      default: return 8'($urandom_range(8'h61, 8'h63));
    endcase
  endfunction

  // Builds a mostly well-formed path with random segments.
  task automatic send_random_path(int unsigned maxseg);
    int unsigned nseg, sel;
    sel = $urandom_range(0, 5);
    if (sel == 0) send_text("C:");
    else if (sel == 1) send_text("/srv");
    else if (sel == 2) send_text("/sr");
    nseg = $urandom_range(0, maxseg);
    for (int unsigned s = 0; s < nseg; s++) begin
      sel = $urandom_range(0, 9);
      send_gapped(ACT_PUSH, ($urandom_range(0, 3) == 0) ? CH_BSLASH : CH_SLASH, 7'd0);
      if (sel == 0) send_text(".");
      else if (sel == 1) send_text("..");
      else if (sel == 2) send_gapped(ACT_PUSH, random_path_char(), 7'd0);
      else begin
        for (int unsigned i = $urandom_range(1, 6); i > 0; i--)
          send_gapped(ACT_PUSH, 8'($urandom_range(8'h61, 8'h7A)), 7'd0);
      end
      if ($urandom_range(0, 15) == 0)
        send_gapped(ACT_READ, 8'($urandom), 7'($urandom));
    end
    send_gapped(ACT_PUSH, CH_NUL, 7'($urandom));
    for (int unsigned i = $urandom_range(0, 4); i > 0; i--)
      send_gapped(ACT_READ, 8'($urandom), 7'($urandom_range(0, 40)));
  endtask

  function automatic path_result_t res(logic [1:0] s, logic [7:0] l, logic [7:0] d);
    path_result_t r;
    r.status = s; r.length = l; r.data = d;
    return r;
  endfunction

  task automatic add_row(logic act, logic [7:0] c, logic [6:0] idx, logic fixed,
                         path_result_t r = '0);
    stim_row_t row;
    row.action = act; row.ch = c; row.idx = idx; row.has_fixed = fixed; row.fixed = r;
    directed.push_back(row);
  endtask

  // Directed table: extremes, both operations, and the special cases.
  task automatic build_table();
    add_row(ACT_READ, 8'hFF, 7'd0, 1'b1, res(ST_OK, 8'd6, "0"));       // After reset.
    add_row(ACT_READ, 8'h00, 7'd127, 1'b1, res(ST_OK, 8'd6, 8'd0));    // Index beyond.
    add_row(ACT_PUSH, CH_NUL, 7'd0, 1'b1, res(ST_OK, 8'd6, 8'd0));     // Empty path.
    add_row(ACT_PUSH, "C", 7'd0, 1'b0);                                // Drive prefix.
    add_row(ACT_PUSH, CH_COLON, 7'd0, 1'b0);
    add_row(ACT_PUSH, CH_SLASH, 7'd0, 1'b0);                           // Jail prefix.
    add_row(ACT_PUSH, "s", 7'd0, 1'b0);
    add_row(ACT_PUSH, "r", 7'd0, 1'b0);
    add_row(ACT_PUSH, "v", 7'd0, 1'b0);
    add_row(ACT_PUSH, CH_BSLASH, 7'd0, 1'b0);
    add_row(ACT_PUSH, 8'hFF, 7'd0, 1'b0);
    add_row(ACT_READ, 8'h00, 7'd6, 1'b0);                              // Read mid-path.
    add_row(ACT_PUSH, CH_SLASH, 7'd0, 1'b0);
    add_row(ACT_PUSH, CH_DOT, 7'd0, 1'b0);
    add_row(ACT_PUSH, CH_SLASH, 7'd0, 1'b0);
    add_row(ACT_PUSH, CH_DOT, 7'd0, 1'b0);
    add_row(ACT_PUSH, CH_DOT, 7'd0, 1'b0);
    add_row(ACT_PUSH, CH_NUL, 7'd0, 1'b1, res(ST_OK, 8'd6, 8'd0));     // Pop to root.
    add_row(ACT_PUSH, CH_SLASH, 7'd0, 1'b0);                           // Escape above root.
    add_row(ACT_PUSH, CH_DOT, 7'd0, 1'b0);
    add_row(ACT_PUSH, CH_DOT, 7'd0, 1'b0);
    add_row(ACT_PUSH, CH_SLASH, 7'd0, 1'b0);
    add_row(ACT_PUSH, "x", 7'd0, 1'b0);                                // Ignored after error.
    add_row(ACT_PUSH, "x", 7'd0, 1'b0);
    add_row(ACT_PUSH, CH_NUL, 7'd0, 1'b1, res(ST_DENIED, 8'd0, 8'd0));
    add_row(ACT_PUSH, CH_NUL, 7'd0, 1'b1, res(ST_OK, 8'd6, 8'd0));     // New path.
    add_row(ACT_READ, 8'h00, 7'd5, 1'b1, res(ST_OK, 8'd6, "v"));
  endtask

  initial begin
    stim_row_t row;
    m_bufsize = 8'd128;
    for (int i = 0; i < PATH_MAX; i++) m_store[i] = 8'd0;
    for (int i = 0; i < STACK_DEPTH; i++) m_starts[i] = 8'd0;
    for (int i = 0; i < 5; i++) m_window[i] = 8'd0;
    restart_path();
    build_table();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows; rows with a typed-in result are checked against it too.
    foreach (directed[i]) begin
      row = directed[i];
      send_gapped(row.action, row.ch, row.idx);
      if (row.has_fixed && expected_results.size() != 0 &&
          expected_results[$] != row.fixed)
        report_mismatch($sformatf("directed row %0d", i),
                        expected_results[$], row.fixed);
    end
    // A segment longer than the store overflows it.
    send_text("/");
    for (int i = 0; i < 130; i++) send_item(ACT_PUSH, 8'h80 | 8'(i), 7'd0, 0);
    send_item(ACT_PUSH, CH_NUL, 7'd0, 0);
    // Too deep: 33 one-letter segments.
    for (int i = 0; i < 33; i++) begin
      send_item(ACT_PUSH, CH_SLASH, 7'd0, 0);
      send_item(ACT_PUSH, "d", 7'd0, 0);
    end
    send_item(ACT_PUSH, CH_NUL, 7'd0, 0);
    // Reads of a 126-byte path at every index, including the top bit.
    for (int i = 0; i < 15; i++) send_text("/abcdefg");
    send_item(ACT_PUSH, CH_NUL, 7'd0, 0);
    for (int i = 0; i < 128; i++) send_item(ACT_READ, 8'd0, 7'(i), 0);
    drain();

    // Random part, across several register settings with the extremes among them.
    for (int phase = 0; phase < 7; phase++) begin
      case (phase)
        0: write_bufsize(8'd0);
        1: write_bufsize(8'd7);
        2: write_bufsize(8'd8);
        3: write_bufsize(8'd20);
        4: write_bufsize(8'd255);
        5: write_bufsize(8'($urandom_range(9, 127)));
        default: write_bufsize(8'd128);
      endcase
      for (int p = 0; p < 7; p++) begin
        if ($urandom_range(0, 7) == 0) begin
          // Noise: arbitrary characters and reads.
          for (int i = $urandom_range(1, 8); i > 0; i--)
            send_gapped(1'($urandom), 8'($urandom), 7'($urandom));
        end else begin
          send_random_path((phase == 4 && p == 3) ? 40 : 10);
        end
        // The output is held off for a long stretch while items keep coming.
        if (phase == 2 && p == 1) receiver_hold = 1'b1;
        if (phase == 2 && p == 4) receiver_hold = 1'b0;
        // The sender pauses until every result is back.
        if (p == 5) drain();
      end
      drain();
    end
    send_item(ACT_PUSH, CH_NUL, 7'd0, 0);
    drain();

    if (expected_results.size() != 0) begin
      report_mismatch("results left waiting", 0, expected_results.size());
    end
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver side: random stalls, plus a long hold when requested.
  // ---------------------------------------------------------------------------
  int unsigned stall_left = 0;
  int unsigned hold_cycles = 0;

  always @(posedge clk_i) begin
    int unsigned wait_draw;
    if (receiver_hold && hold_cycles < 400) begin
      hold_cycles <= hold_cycles + 1;
      out_stall_i <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left  <= stall_left - 1;
      out_stall_i <= (stall_left > 1);
    end else if (out_valid_o && !out_stall_i) begin
      // A transaction moves at this edge; draw the wait before the next one.
      wait_draw   = $urandom_range(0, 11);
      stall_left  <= wait_draw;
      out_stall_i <= (wait_draw != 0);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Compares each accepted result, field by field, with the oldest expectation.
  always @(posedge clk_i) begin
    path_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", status_o, 0);
      end else begin
        want = expected_results.pop_front();
        if (status_o != want.status) report_mismatch("status", status_o, want.status);
        if (path_length_o != want.length)
          report_mismatch("path_length", path_length_o, want.length);
        if (out_byte_o != want.data) report_mismatch("out_byte", out_byte_o, want.data);
      end
    end
  end

  // Watchdog for a hung handshake.
  initial begin
    #20ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

>>> jailed_path_normalizer.f
sv/jpn_pkg.sv
sv/jpn_prefix.sv
sv/jpn_path_mem.sv
sv/jpn_seg_stack.sv
sv/jailed_path_normalizer.sv
bench/testbench.sv
